/* rtl/cmg_pkg.sv */
// Package for the calendar month grid block.
// Holds the sequencer state type, the constants and the month tables.
// No dependencies.
package cmg_pkg;

    localparam int YearW      = 14;
    localparam int MonthW     = 4;
    localparam int DayW       = 5;
    localparam int ColW       = 3;
    localparam int RowW       = 3;
    localparam int SumW       = 15;
    localparam int QuoW       = 8;
    localparam int ProdW      = 2 * YearW;
    localparam int RecipShift = 20;

    localparam logic [YearW-1:0]  YearReset  = YearW'(2024);
    // 2^20 / 100 rounded up; exact quotient for every 14-bit year
    localparam logic [YearW-1:0]  Recip100   = YearW'(10486);
    localparam logic [SumW-1:0]   Century    = SumW'(100);
    localparam logic [SumW-1:0]   CenturyEnd = SumW'(99);
    localparam logic [MonthW-1:0] MonthFirst = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
    localparam logic [MonthW-1:0] MonthLast  = 4'd12;
    localparam logic [ColW-1:0]   ColLast    = 3'd6;
    localparam logic [ColW-1:0]   Monday     = 3'd1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SUM  = 5'b00100,
        S_MOD  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        unique case (m)
            4'd2:                        len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the month, modulo 7, common year
    function automatic logic [ColW-1:0] month_offset(input logic [MonthW-1:0] m);
        logic [ColW-1:0] off;
        unique case (m)
            4'd2, 4'd3, 4'd11: off = 3'd3;
            4'd4, 4'd7:        off = 3'd6;
            4'd5:              off = 3'd1;
            4'd6:              off = 3'd4;
            4'd8:              off = 3'd2;
            4'd9, 4'd12:       off = 3'd5;
            default:           off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

/* rtl/calendar_month_grid.sv */
// Calendar month grid: lays out one month of the configured year, one cell per day.
// Depends on cmg_pkg.
//
// channel   dir  ports                                                  handshake
// request   in   i_month_number                                         start & !busy
// result    out  o_day_of_month, o_weekday_column, o_week_row, o_last_day   o_strobe
// config    in   i_year_setting                                         i_year_we
//
// A request finds day 1 in states S_DIV (divide by 100 by reciprocal multiply),
// S_SUM (sum) and S_MOD (fold and month offset), then gives one day per cycle;
// busy stays high through the last day, and the next request is taken in the cycle after it.
// A month outside 1 to 12 is dropped without results. The reset is synchronous
// and puts the year at 2024. Results cannot be stalled.
module calendar_month_grid (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cmg_pkg::MonthW-1:0] i_month_number,
    input  logic                       i_year_we,
    input  logic [cmg_pkg::YearW-1:0]  i_year_setting,
    output logic                       o_strobe,
    output logic [cmg_pkg::DayW-1:0]   o_day_of_month,
    output logic [cmg_pkg::ColW-1:0]   o_weekday_column,
    output logic [cmg_pkg::RowW-1:0]   o_week_row,
    output logic                       o_last_day
);
    import cmg_pkg::*;

    t_state            r_state, n_state;
    logic [YearW-1:0]  r_year;
    logic [MonthW-1:0] r_month, n_month;
    logic [YearW-1:0]  r_p, n_p;
    logic              r_y0, n_y0;
    logic [QuoW-1:0]   r_quo, n_quo;
    logic [SumW-1:0]   r_sum, n_sum;
    logic              r_leap, n_leap;
    logic [DayW-1:0]   r_day, n_day;
    logic [DayW-1:0]   r_len, n_len;
    logic [ColW-1:0]   r_col, n_col;
    logic [RowW-1:0]   r_row, n_row;

    logic [ProdW-1:0]  prod;
    logic              century_end;
    logic [5:0]        fold1;
    logic [3:0]        fold2;
    logic [ColW-1:0]   jan1;
    logic [3:0]        first_sum;
    logic [ColW-1:0]   first;
    logic              valid_month;

    always_comb begin
        prod        = ProdW'(r_p) * ProdW'(Recip100);
        century_end = (SumW'(r_p) == SumW'(r_quo) * Century + CenturyEnd);
        fold1     = 6'(r_sum[14:12]) + 6'(r_sum[11:9]) + 6'(r_sum[8:6])
                  + 6'(r_sum[5:3]) + 6'(r_sum[2:0]);
        fold2     = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        jan1      = r_y0 ? Monday : ((fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0]);
        first_sum = 4'(jan1) + 4'(month_offset(r_month))
                  + 4'(r_leap && (r_month > MonthFeb));
        first     = (first_sum >= 4'd7) ? 3'(first_sum - 4'd7) : first_sum[2:0];
        valid_month = (i_month_number >= MonthFirst) && (i_month_number <= MonthLast);
    end

    always_comb begin
        n_state = r_state;
        n_month = r_month;
        n_p     = r_p;
        n_y0    = r_y0;
        n_quo   = r_quo;
        n_sum   = r_sum;
        n_leap  = r_leap;
        n_day   = r_day;
        n_len   = r_len;
        n_col   = r_col;
        n_row   = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (start && valid_month) begin
                    n_month = i_month_number;
                    n_y0    = (r_year == '0);
                    n_p     = r_year - YearW'(1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo   = prod[RecipShift +: QuoW];
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum  = SumW'(r_p) + SumW'(r_p >> 2) - SumW'(r_quo)
                       + SumW'(r_quo >> 2) + SumW'(1);
                n_leap = r_y0 || (century_end ? (r_quo[1:0] == 2'b11)
                                              : (r_p[1:0] == 2'b11));
                n_state = S_MOD;
            end
            S_MOD: begin
                n_col   = first;
                n_row   = '0;
                n_day   = DayW'(1);
                n_len   = month_len(r_month, r_leap);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_day = r_day + DayW'(1);
                if (r_col == ColLast) begin
                    n_col = '0;
                    n_row = r_row + RowW'(1);
                end else begin
                    n_col = r_col + ColW'(1);
                end
                if (r_day == r_len) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_year  <= YearReset;
        end else begin
            r_state <= n_state;
            if (i_year_we) begin
                r_year <= i_year_setting;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_month <= n_month;
        r_p     <= n_p;
        r_y0    <= n_y0;
        r_quo   <= n_quo;
        r_sum   <= n_sum;
        r_leap  <= n_leap;
        r_day   <= n_day;
        r_len   <= n_len;
        r_col   <= n_col;
        r_row   <= n_row;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = (r_state == S_EMIT);
    assign o_day_of_month   = r_day;
    assign o_weekday_column = r_col;
    assign o_week_row       = r_row;
    assign o_last_day       = (r_day == r_len);

endmodule
